FILE: hdl/dfcl_pkg.sv
// Package with the shared types and constants of the deduplicating fault code log.
`timescale 1ns / 1ps

package dfcl_pkg;

  localparam int CODE_W = 32;
  localparam int CNT_W = 6;
  localparam logic [CODE_W-1:0] EMPTY_CODE = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd32;

  typedef enum logic [1:0] {
    KIND_LOG    = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_ENTRY   = 3'd3,
    ST_NONE    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOG_SCAN,
    S_LOG_FIN,
    S_RD_SCAN,
    S_RD_FIN,
    S_CLR_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_log;
    logic scan_rd;
    logic log_fin;
    logic rd_fin;
    logic clr_fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/dfcl_ctrl.sv
// Controller state machine of the deduplicating fault code log.
`timescale 1ns / 1ps

module dfcl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic [1:0]     kind,
  output logic           s_tready,
  input  dfcl_pkg::sts_t sts,
  output dfcl_pkg::cmd_t cmd
);

  dfcl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfcl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      dfcl_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (dfcl_pkg::kind_t'(kind))
            dfcl_pkg::KIND_LOG:   state_next = dfcl_pkg::S_LOG_SCAN;
            dfcl_pkg::KIND_READ:  state_next = dfcl_pkg::S_RD_SCAN;
            dfcl_pkg::KIND_CLEAR: state_next = dfcl_pkg::S_CLR_FIN;
            default:              state_next = dfcl_pkg::S_IDLE;
          endcase
        end
      end
      dfcl_pkg::S_LOG_SCAN: begin
        cmd.scan_log = 1'b1;
        if (sts.scan_done) state_next = dfcl_pkg::S_LOG_FIN;
      end
      dfcl_pkg::S_LOG_FIN: begin
        if (sts.out_free) begin
          cmd.log_fin = 1'b1;
          state_next = dfcl_pkg::S_IDLE;
        end
      end
      dfcl_pkg::S_RD_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_done) state_next = dfcl_pkg::S_RD_FIN;
      end
      dfcl_pkg::S_RD_FIN: begin
        if (sts.out_free) begin
          cmd.rd_fin = 1'b1;
          state_next = dfcl_pkg::S_IDLE;
        end
      end
      dfcl_pkg::S_CLR_FIN: begin
        if (sts.out_free) begin
          cmd.clr_fin = 1'b1;
          state_next = dfcl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dfcl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/dfcl_dp.sv
// Datapath of the deduplicating fault code log: slot memory, scan pipeline and output register.
`timescale 1ns / 1ps

module dfcl_dp #(
  parameter int SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dfcl_pkg::cmd_t                cmd,
  output dfcl_pkg::sts_t                sts,
  input  logic [dfcl_pkg::CODE_W-1:0]   fault_code,
  output logic                          out_v,
  input  logic                          out_ready,
  output dfcl_pkg::status_t             out_status,
  output logic [dfcl_pkg::CODE_W-1:0]   out_code,
  output logic [dfcl_pkg::CNT_W-1:0]    out_count,
  output logic                          out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic [dfcl_pkg::CODE_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]            vld;

  logic [dfcl_pkg::CODE_W-1:0] code_q;
  logic [IW-1:0]               idx;
  logic                        iss_done;
  logic                        rd_ok;
  logic [dfcl_pkg::CODE_W-1:0] rd_code;
  logic                        rd_vld;
  logic [IW-1:0]               rd_idx;
  logic                        found;
  logic                        have_free;
  logic [IW-1:0]               free_idx;
  logic                        pend_v;
  logic [dfcl_pkg::CODE_W-1:0] pend_code;
  logic [dfcl_pkg::CNT_W-1:0]  count;

  logic [dfcl_pkg::CODE_W-1:0] eff;
  logic                        scan, take, emit_entry, stall, adv, issue, out_free;
  logic                        wr_en, out_load, out_v_next;

  // A slot that was not written since reset or the last clear reads as empty.
  assign eff        = rd_vld ? rd_code : dfcl_pkg::EMPTY_CODE;
  assign out_free   = !out_v || out_ready;
  assign scan       = cmd.scan_log || cmd.scan_rd;
  assign take       = cmd.scan_rd && rd_ok && (eff != dfcl_pkg::EMPTY_CODE) &&
                      (count < dfcl_pkg::MAX_RESULTS);
  assign emit_entry = take && pend_v;
  assign stall      = emit_entry && !out_free;
  assign adv        = scan && !stall;
  assign issue      = adv && !iss_done;
  assign wr_en      = cmd.log_fin && !found && have_free;
  assign out_load   = (emit_entry && adv) || cmd.log_fin || cmd.rd_fin || cmd.clr_fin;
  assign out_v_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_v);

  assign sts.scan_done = iss_done && !rd_ok;
  assign sts.out_free  = out_free;

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[free_idx] <= code_q;
    if (issue) begin
      rd_code <= mem[idx];
      rd_vld  <= vld[idx];
      rd_idx  <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_fin) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[free_idx] <= 1'b1;
    end
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      iss_done <= 1'b1;
      rd_ok    <= 1'b0;
      pend_v   <= 1'b0;
    end else if (cmd.load) begin
      idx      <= '0;
      iss_done <= 1'b0;
      rd_ok    <= 1'b0;
      pend_v   <= 1'b0;
    end else begin
      if (adv) rd_ok <= issue;
      if (issue) begin
        idx <= idx + 1'b1;
        if (idx == LAST_IDX) iss_done <= 1'b1;
      end
      if (take && adv) pend_v <= 1'b1;
    end
  end

  // Search results and pending read entry.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_q    <= fault_code;
      found     <= 1'b0;
      have_free <= 1'b0;
      free_idx  <= '0;
      count     <= '0;
    end else begin
      if (cmd.scan_log && rd_ok) begin
        if (eff == code_q) found <= 1'b1;
        if (!have_free && eff == dfcl_pkg::EMPTY_CODE) begin
          have_free <= 1'b1;
          free_idx  <= rd_idx;
        end
      end
      if (take && adv) begin
        pend_code <= eff;
        count     <= count + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_entry && adv) begin
      out_status <= dfcl_pkg::ST_ENTRY;
      out_code   <= pend_code;
      out_count  <= count;
      out_last   <= 1'b0;
    end else if (cmd.log_fin) begin
      out_status <= found ? dfcl_pkg::ST_PRESENT :
                    (have_free ? dfcl_pkg::ST_NEW : dfcl_pkg::ST_FULL);
      out_code   <= code_q;
      out_count  <= '0;
      out_last   <= 1'b1;
    end else if (cmd.rd_fin) begin
      out_status <= pend_v ? dfcl_pkg::ST_ENTRY : dfcl_pkg::ST_NONE;
      out_code   <= pend_v ? pend_code : '0;
      out_count  <= pend_v ? count : '0;
      out_last   <= 1'b1;
    end else if (cmd.clr_fin) begin
      out_status <= dfcl_pkg::ST_CLEARED;
      out_code   <= '0;
      out_count  <= '0;
      out_last   <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> out_count <= dfcl_pkg::MAX_RESULTS)
    else $error("entry count above limit");

  a_entry_cnt: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_status == dfcl_pkg::ST_ENTRY) |-> out_count != '0)
    else $error("entry result without a count");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_status != dfcl_pkg::ST_ENTRY) |-> out_last)
    else $error("single result not marked last");

  a_no_empty_wr: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> code_q != dfcl_pkg::EMPTY_CODE)
    else $error("empty marker written into a slot");

  a_no_load_over: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten");
`endif

endmodule

FILE: hdl/dedup_fault_code_log.sv
// Top level of the deduplicating fault code log.
`timescale 1ns / 1ps

// The block keeps a table of SLOTS 32-bit fault codes, where all ones marks an
// empty slot, and takes one input transaction at a time. The kind in s_tuser
// selects the operation: a log transaction scans every slot and reports the
// code as already present, stores it in the lowest empty slot as new, or
// reports the table full; a read-all transaction returns each stored code in
// slot order with a running count (at most 32 entries), marking the final one
// with tlast, or a single no-entries result when the table is empty; a clear
// transaction empties every slot. Kind 3 is accepted and ignored. Every log,
// read-all or clear ends with exactly one result marked by tlast. The table
// lives in a memory with one read port, so a log or read-all scans one slot
// per clock, except that a read-all scan pauses while the output side stalls.
// Each slot has a valid bit that reset and clear drop at once, so no clearing
// pass follows reset.
module dedup_fault_code_log #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] fault_code
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] code_out, [37:32] entry_count, [39:38] zero
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast
);

  dfcl_pkg::cmd_t               cmd;
  dfcl_pkg::sts_t               sts;
  dfcl_pkg::status_t            out_status;
  logic [dfcl_pkg::CODE_W-1:0]  out_code;
  logic [dfcl_pkg::CNT_W-1:0]   out_count;

  dfcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfcl_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .fault_code (s_tdata),
    .out_v      (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_code   (out_code),
    .out_count  (out_count),
    .out_last   (m_tlast)
  );

  assign m_tdata = {2'b00, out_count, out_code};
  assign m_tuser = out_status;

endmodule

FILE: verif/dedup_fault_code_log_tb.sv
// Self-checking testbench for the deduplicating fault code log.
`timescale 1ns / 1ps

module dedup_fault_code_log_tb;

  localparam int TABLE_SLOTS = 32;
  localparam int ITEM_TARGET = 232;
  // Cycles with no transaction on either side before the run is abandoned.
  // This is far beyond the longest scan or stall of any correct run.
  localparam int IDLE_LIMIT = 4000;
  // Quiet time after the last expected result, to catch stray results.
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    dfcl_pkg::status_t           status;
    logic [dfcl_pkg::CODE_W-1:0] code;
    logic [dfcl_pkg::CNT_W-1:0]  count;
    logic                        last;
  } fault_result_t;

  // Mirror of the slot table plus the queue of results it predicts.
  class fault_log_scoreboard;
    logic [dfcl_pkg::CODE_W-1:0] slot_code [TABLE_SLOTS];
    fault_result_t               expected_q [$];
    int unsigned                 failures;

    function new();
      failures = 0;
      empty_table();
    endfunction

    function void empty_table();
      foreach (slot_code[i]) slot_code[i] = dfcl_pkg::EMPTY_CODE;
    endfunction

    // Records one accepted input transaction and queues its results.
    function void note_item(logic [1:0] kind, logic [dfcl_pkg::CODE_W-1:0] code);
      fault_result_t res;
      bit found;
      bit have_free;
      int free_idx;
      int n;
      found = 1'b0;
      have_free = 1'b0;
      free_idx = 0;
      n = 0;
      res.code = code;
      res.count = '0;
      res.last = 1'b1;
      case (kind)
        dfcl_pkg::KIND_LOG: begin
          // A match anywhere wins over an earlier empty slot; logging the
          // empty marker itself matches the first empty slot.
          for (int i = 0; i < TABLE_SLOTS && !found; i++) begin
            if (slot_code[i] == code) begin
              found = 1'b1;
            end else if (!have_free && slot_code[i] == dfcl_pkg::EMPTY_CODE) begin
              have_free = 1'b1;
              free_idx = i;
            end
          end
          if (found) begin
            res.status = dfcl_pkg::ST_PRESENT;
          end else if (!have_free) begin
            res.status = dfcl_pkg::ST_FULL;
          end else begin
            slot_code[free_idx] = code;
            res.status = dfcl_pkg::ST_NEW;
          end
          expected_q.push_back(res);
        end
        dfcl_pkg::KIND_READ: begin
          for (int i = 0; i < TABLE_SLOTS && n < dfcl_pkg::MAX_RESULTS; i++) begin
            if (slot_code[i] != dfcl_pkg::EMPTY_CODE) begin
              n++;
              res.status = dfcl_pkg::ST_ENTRY;
              res.code = slot_code[i];
              res.count = dfcl_pkg::CNT_W'(n);
              res.last = 1'b0;
              expected_q.push_back(res);
            end
          end
          if (n == 0) begin
            res.status = dfcl_pkg::ST_NONE;
            res.code = '0;
            res.count = '0;
            res.last = 1'b1;
            expected_q.push_back(res);
          end else begin
            expected_q[expected_q.size() - 1].last = 1'b1;
          end
        end
        dfcl_pkg::KIND_CLEAR: begin
          empty_table();
          res.status = dfcl_pkg::ST_CLEARED;
          res.code = '0;
          expected_q.push_back(res);
        end
        default: ;  // the unused kind changes nothing and gives no result
      endcase
    endfunction

    // Compares one accepted output transaction with the oldest expectation.
    function void check_result(logic [2:0] status, logic [dfcl_pkg::CODE_W-1:0] code,
                               logic [dfcl_pkg::CNT_W-1:0] count, logic last);
      fault_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status %0d code %h", status, code);
        failures++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, status);
        failures++;
      end
      if (code !== exp_res.code) begin
        $error("code_out: expected %h, actual %h", exp_res.code, code);
        failures++;
      end
      if (count !== exp_res.count) begin
        $error("entry_count: expected %0d, actual %0d", exp_res.count, count);
        failures++;
      end
      if (last !== exp_res.last) begin
        $error("last: expected %0d, actual %0d", exp_res.last, last);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int stored_count();
      int k;
      k = 0;
      foreach (slot_code[i]) if (slot_code[i] != dfcl_pkg::EMPTY_CODE) k++;
      return k;
    endfunction

    // Codes fill the table from slot 0 with no holes, so any index below the
    // stored count holds a code.
    function logic [dfcl_pkg::CODE_W-1:0] pick_stored();
      int k;
      k = stored_count();
      if (k == 0) return $urandom;
      return slot_code[$urandom_range(0, k - 1)];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  fault_log_scoreboard sb = new();
  bit steady = 1'b0;   // when set, neither side idles
  int sink_hold = 0;
  int sink_gap;
  int idle_cycles = 0;

  dedup_fault_code_log #(
    .SLOTS(TABLE_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Output side: ready runs broken by stalls of random length.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (!m_tready || steady) begin
      m_tready <= 1'b1;
      sink_hold <= $urandom_range(0, 30);
    end else begin
      sink_gap = idle_len();
      if (sink_gap > 0) begin
        m_tready <= 1'b0;
        sink_hold <= sink_gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tuser, m_tdata[31:0], m_tdata[37:32], m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one transaction and returns at the edge where it is accepted.
  // tvalid is left high so a back-to-back transaction needs no second
  // assignment in the same step.
  task automatic send_item(input logic [1:0] kind, input logic [31:0] code);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= code;
    do @(posedge clk); while (!s_tready);
    sb.note_item(kind, code);
  endtask

  // Holds the input side until every expected result has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // Fills the table with fresh codes, then hits it while full.
  task automatic fill_table(inout int unsigned issued);
    while (sb.stored_count() < TABLE_SLOTS) begin
      send_item(dfcl_pkg::KIND_LOG, $urandom);
      issued++;
    end
    send_item(dfcl_pkg::KIND_LOG, dfcl_pkg::EMPTY_CODE);
    send_item(dfcl_pkg::KIND_LOG, $urandom);
    send_item(dfcl_pkg::KIND_LOG, sb.pick_stored());
    send_item(dfcl_pkg::KIND_READ, $urandom);
    issued += 4;
  endtask

  initial begin
    int unsigned issued;
    int unsigned pick;
    int unsigned code_sel;
    logic [31:0] code;
    issued = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-table read, the empty marker, extremes, duplicates,
    // the unused kind, and a clear followed by a read.
    send_item(dfcl_pkg::KIND_READ, 32'h0);
    send_item(dfcl_pkg::KIND_LOG, dfcl_pkg::EMPTY_CODE);
    send_item(dfcl_pkg::KIND_LOG, 32'h0000_0000);
    send_item(dfcl_pkg::KIND_LOG, 32'h0000_0000);
    send_item(dfcl_pkg::KIND_LOG, 32'h8000_0000);
    send_item(dfcl_pkg::KIND_LOG, 32'h7FFF_FFFF);
    send_item(dfcl_pkg::KIND_LOG, 32'hFFFF_FFFE);
    send_item(dfcl_pkg::KIND_LOG, 32'h0000_0001);
    send_item(dfcl_pkg::KIND_LOG, 32'h7FFF_FFFF);
    send_item(dfcl_pkg::KIND_LOG, dfcl_pkg::EMPTY_CODE);
    send_item(dfcl_pkg::KIND_READ, 32'hFFFF_FFFF);
    send_item(dfcl_pkg::KIND_UNUSED, 32'hA5A5_A5A5);
    send_item(dfcl_pkg::KIND_READ, 32'h5A5A_5A5A);
    drain_results();
    send_item(dfcl_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
    send_item(dfcl_pkg::KIND_READ, 32'h0);
    send_item(dfcl_pkg::KIND_LOG, 32'h0000_0001);
    send_item(dfcl_pkg::KIND_READ, 32'h0);
    send_item(dfcl_pkg::KIND_CLEAR, 32'h0);

    // Random: one forced fill to the full table, then a mix of logs with
    // frequent repeats, reads, clears, further fills and ignored kinds.
    fill_table(issued);
    while (issued < ITEM_TARGET) begin
      if ($urandom_range(0, 29) == 0) steady <= ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 19) == 0) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(dfcl_pkg::KIND_CLEAR, $urandom);
        issued++;
      end else if (pick < 16) begin
        send_item(dfcl_pkg::KIND_READ, $urandom);
        issued++;
      end else if (pick < 19) begin
        send_item(dfcl_pkg::KIND_UNUSED, $urandom);
        issued++;
      end else if (pick < 21) begin
        fill_table(issued);
      end else begin
        code_sel = $urandom_range(0, 99);
        if (code_sel < 40) begin
          code = sb.pick_stored();
        end else if (code_sel < 45) begin
          code = dfcl_pkg::EMPTY_CODE;
        end else if (code_sel < 52) begin
          case ($urandom_range(0, 3))
            0: code = 32'h0000_0000;
            1: code = 32'h8000_0000;
            2: code = 32'h7FFF_FFFF;
            default: code = 32'hFFFF_FFFE;
          endcase
        end else begin
          code = $urandom;
        end
        send_item(dfcl_pkg::KIND_LOG, code);
        issued++;
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/dfcl_pkg.sv
hdl/dfcl_ctrl.sv
hdl/dfcl_dp.sv
hdl/dedup_fault_code_log.sv
verif/dedup_fault_code_log_tb.sv
